>>> sv/has_pkg.sv
// ----------------------------------------------------------------------------
// Hungarian assignment solver package
// Shared types, sizes and codes for the solver controller and datapath.
// ----------------------------------------------------------------------------
package has_pkg;

    localparam int MAX_DIM     = 16;
    localparam int COST_BITS   = 24;
    localparam int DIM_W       = 5;
    localparam int IDX_W       = 4;
    localparam int COL_W       = 5;
    localparam int ADDR_W      = 8;
    localparam int POT_W       = 48;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
    localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};
    localparam logic [POT_W-1:0] ONE_Q8 = POT_W'(256);

    // Register byte addresses.
    localparam logic [2:0] REG_ROW_COUNT = 3'd0;
    localparam logic [2:0] REG_COL_COUNT = 3'd4;

    typedef struct packed {
        logic signed [COST_BITS-1:0] cost_value;
        logic                        feasible;
    } has_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] assigned_column;
        logic             matched;
        logic             last_row;
    } has_out_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_BIG,
        ST_INIT,
        ST_PH_START,
        ST_IT_START,
        ST_SCAN_RD,
        ST_SCAN,
        ST_UPD,
        ST_AUG,
        ST_RES_CLR,
        ST_RES_SCAN,
        ST_RES_RD,
        ST_RES_CHK,
        ST_EMIT
    } has_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic big;
        logic init;
        logic ph_start;
        logic it_start;
        logic scan_rd;
        logic scan;
        logic upd;
        logic aug;
        logic res_clr;
        logic res_scan;
        logic res_rd;
        logic res_chk;
        logic emit_pop;
    } has_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic load_done;
        logic scan_last;
        logic upd_last;
        logic phase_done;
        logic aug_done;
        logic solve_done;
        logic res_last;
        logic emit_last;
    } has_sts_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    function automatic logic signed [POT_W-1:0] sat_add(input logic signed [POT_W-1:0] a,
                                                         input logic signed [POT_W-1:0] b);
        logic signed [POT_W:0] s;
        s = {a[POT_W-1], a} + {b[POT_W-1], b};
        if (s[POT_W] != s[POT_W-1]) return s[POT_W] ? POT_MIN : POT_MAX;
        return s[POT_W-1:0];
    endfunction

    function automatic logic signed [POT_W-1:0] sat_sub(input logic signed [POT_W-1:0] a,
                                                         input logic signed [POT_W-1:0] b);
        logic signed [POT_W:0] s;
        s = {a[POT_W-1], a} - {b[POT_W-1], b};
        if (s[POT_W] != s[POT_W-1]) return s[POT_W] ? POT_MIN : POT_MAX;
        return s[POT_W-1:0];
    endfunction

endpackage

>>> sv/has_ctrl.sv
// ----------------------------------------------------------------------------
// Hungarian solver controller
// Sequences loading, the phases of the shortest-path solve and the results.
// ----------------------------------------------------------------------------
module has_ctrl import has_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       m_ready,
    input  logic       cfg_wr,
    input  has_sts_t   sts,
    output logic       s_ready,
    output logic       m_valid,
    output has_cmd_t   cmd
);

    has_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && !cfg_wr && sts.load_done) state_next = ST_BIG;
            end
            ST_BIG:      state_next = ST_INIT;
            ST_INIT:     state_next = ST_PH_START;
            ST_PH_START: state_next = ST_IT_START;
            ST_IT_START: state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN;
            ST_SCAN: begin
                state_next = sts.scan_last ? ST_UPD : ST_SCAN_RD;
            end
            ST_UPD: begin
                if (sts.upd_last) state_next = sts.phase_done ? ST_AUG : ST_IT_START;
            end
            ST_AUG: begin
                if (sts.aug_done) state_next = sts.solve_done ? ST_RES_CLR : ST_PH_START;
            end
            ST_RES_CLR:  state_next = ST_RES_SCAN;
            ST_RES_SCAN: state_next = ST_RES_RD;
            ST_RES_RD:   state_next = ST_RES_CHK;
            ST_RES_CHK:  state_next = sts.res_last ? ST_EMIT : ST_RES_SCAN;
            ST_EMIT: begin
                if (m_ready && sts.emit_last) state_next = ST_LOAD;
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_ready  = (state_reg == ST_LOAD) && !cfg_wr;
        m_valid  = (state_reg == ST_EMIT);
        cmd.load     = (state_reg == ST_LOAD) && s_valid && !cfg_wr;
        cmd.big      = (state_reg == ST_BIG);
        cmd.init     = (state_reg == ST_INIT);
        cmd.ph_start = (state_reg == ST_PH_START);
        cmd.it_start = (state_reg == ST_IT_START);
        cmd.scan_rd  = (state_reg == ST_SCAN_RD);
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.upd      = (state_reg == ST_UPD);
        cmd.aug      = (state_reg == ST_AUG);
        cmd.res_clr  = (state_reg == ST_RES_CLR);
        cmd.res_scan = (state_reg == ST_RES_SCAN);
        cmd.res_rd   = (state_reg == ST_RES_RD);
        cmd.res_chk  = (state_reg == ST_RES_CHK);
        cmd.emit_pop = (state_reg == ST_EMIT) && m_ready;
    end

endmodule

>>> sv/has_dp.sv
// ----------------------------------------------------------------------------
// Hungarian solver datapath
// Matrix store, potentials, slacks and the assignment, stepped by commands.
// ----------------------------------------------------------------------------
module has_dp import has_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr,
    input  logic [DIM_W-1:0] row_count,
    input  logic [DIM_W-1:0] col_count,
    input  has_in_t          s_data,
    input  has_cmd_t         cmd,
    output has_sts_t         sts,
    output has_out_t         m_data
);

    localparam int MW = MAX_DIM + 1;

    // Matrix store.
    logic signed [COST_BITS-1:0] cost_mem [STORE_DEPTH];
    logic                        feas_mem [STORE_DEPTH];
    logic signed [COST_BITS-1:0] rd_cost_reg;
    logic                        rd_feas_reg;

    logic [ADDR_W:0]    load_pos_reg;
    logic [COST_BITS:0] largest_reg;

    logic [DIM_W-1:0] rows, cols, n_dim, m_dim;
    logic             tr;
    logic [ADDR_W:0]  total;

    logic signed [POT_W-1:0] big_reg;
    logic signed [POT_W-1:0] u_reg     [MW];
    logic signed [POT_W-1:0] v_reg     [MW];
    logic signed [POT_W-1:0] minv_reg  [MW];
    logic [COL_W-1:0]        owner_reg [MW];
    logic [COL_W-1:0]        way_reg   [MW];
    logic [MW-1:0]           used_reg;
    logic [MW-1:0]           mset_reg;

    logic [COL_W-1:0]        i_reg;     // current phase row (1-based)
    logic [COL_W-1:0]        j0_reg;
    logic [COL_W-1:0]        j1_reg;
    logic [COL_W-1:0]        i0_reg;
    logic [COL_W-1:0]        j_reg;     // scan / update / result index
    logic signed [POT_W-1:0] delta_reg;
    logic signed [POT_W-1:0] u_i0_reg;

    logic             res_ok_reg   [MAX_DIM];
    logic [IDX_W-1:0] res_col_reg  [MAX_DIM];
    logic [IDX_W-1:0] pend_row_reg, pend_col_reg;
    logic [IDX_W-1:0] emit_reg;

    assign rows  = eff_dim(row_count);
    assign cols  = eff_dim(col_count);
    assign tr    = rows > cols;
    assign n_dim = tr ? cols : rows;
    assign m_dim = tr ? rows : cols;
    assign total = (ADDR_W+1)'({4'd0, rows} * {4'd0, cols});

    // Store address for scan (row i0-1, column j-1) or result check.
    logic [IDX_W-1:0] a_r, a_c, sr, sc;
    logic [ADDR_W-1:0] rd_addr;
    always_comb begin
        sr = cmd.res_rd ? pend_row_reg : IDX_W'(i0_reg - COL_W'(1));
        sc = cmd.res_rd ? pend_col_reg : IDX_W'(j_reg - COL_W'(1));
        a_r = (tr && !cmd.res_rd) ? sc : sr;
        a_c = (tr && !cmd.res_rd) ? sr : sc;
        rd_addr = ADDR_W'(a_r * cols + {4'd0, a_c});
    end

    // Load writes and the single registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cost_mem[load_pos_reg[ADDR_W-1:0]] <= s_data.cost_value;
            feas_mem[load_pos_reg[ADDR_W-1:0]] <= s_data.feasible;
        end
        rd_cost_reg <= cost_mem[rd_addr];
        rd_feas_reg <= feas_mem[rd_addr];
    end

    logic [COST_BITS:0] mag;
    assign mag = s_data.cost_value[COST_BITS-1] ?
                 -{s_data.cost_value[COST_BITS-1], s_data.cost_value} :
                 {1'b0, s_data.cost_value};

    // Load position and largest magnitude.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
            largest_reg  <= '0;
        end else if (cfg_wr || cmd.res_clr) begin
            load_pos_reg <= '0;
            largest_reg  <= '0;
        end else if (cmd.load) begin
            load_pos_reg <= ((load_pos_reg >= total) ? '0 : load_pos_reg) + 1'b1;
            if (s_data.feasible && mag > largest_reg) largest_reg <= mag;
        end
    end

    always_comb begin
        sts.load_done = (((load_pos_reg >= total) ? '0 : load_pos_reg) + 1'b1) >= total;
    end

    // Scan arithmetic: cur = cost - u[i0] - v[j].
    logic signed [POT_W-1:0] ecost, cur, sl_new;
    logic                    take;
    always_comb begin
        ecost  = rd_feas_reg ? POT_W'(rd_cost_reg) : big_reg;
        cur    = sat_sub(sat_sub(ecost, u_i0_reg), v_reg[j_reg]);
        take   = !mset_reg[j_reg] || (cur < minv_reg[j_reg]);
        sl_new = take ? cur : minv_reg[j_reg];
    end

    // Infeasible penalty; the product stays well inside 32 bits.
    logic [31:0]      bigu;
    logic [COL_W:0]   dsum;
    assign dsum = {1'b0, rows} + {1'b0, cols} + 1'b1;
    assign bigu = ({7'd0, largest_reg} + ONE_Q8[31:0]) * {26'd0, dsum};

    always_ff @(posedge aclk) begin
        if (cmd.big) begin
            big_reg <= {16'd0, bigu};
        end
        if (cmd.init) begin
            for (int k = 0; k < MW; k++) begin
                u_reg[k]     <= '0;
                v_reg[k]     <= '0;
                owner_reg[k] <= '0;
                way_reg[k]   <= '0;
            end
            i_reg <= COL_W'(1);
        end
        if (cmd.ph_start) begin
            owner_reg[0] <= i_reg;
            j0_reg       <= '0;
            used_reg     <= '0;
            mset_reg     <= '0;
            for (int k = 0; k < MW; k++) minv_reg[k] <= POT_MAX;
        end
        if (cmd.it_start) begin
            used_reg[j0_reg] <= 1'b1;
            i0_reg    <= owner_reg[j0_reg];
            u_i0_reg  <= u_reg[owner_reg[j0_reg]];
            j1_reg    <= '0;
            delta_reg <= POT_MAX;
            j_reg     <= COL_W'(1);
        end
        // Scan a column: store read, then compare.
        if (cmd.scan) begin
            if (!used_reg[j_reg]) begin
                minv_reg[j_reg] <= sl_new;
                mset_reg[j_reg] <= 1'b1;
                if (take) way_reg[j_reg] <= j0_reg;
                if (j1_reg == '0 || sl_new < delta_reg) begin
                    delta_reg <= sl_new;
                    j1_reg    <= j_reg;
                end
            end
            j_reg <= (j_reg == m_dim) ? '0 : j_reg + 1'b1;
        end
        // One column a cycle: shift potentials by delta.
        if (cmd.upd) begin
            if (used_reg[j_reg]) begin
                u_reg[owner_reg[j_reg]] <= sat_add(u_reg[owner_reg[j_reg]], delta_reg);
                v_reg[j_reg] <= sat_sub(v_reg[j_reg], delta_reg);
            end else begin
                minv_reg[j_reg] <= sat_sub(minv_reg[j_reg], delta_reg);
            end
            j_reg <= j_reg + 1'b1;
            if (j_reg == m_dim) j0_reg <= j1_reg;
        end
        // Walk back along the path one link a cycle.
        if (cmd.aug) begin
            owner_reg[j0_reg] <= owner_reg[way_reg[j0_reg]];
            j0_reg <= way_reg[j0_reg];
            if (way_reg[j0_reg] == '0) i_reg <= i_reg + 1'b1;
        end
        if (cmd.res_clr) begin
            for (int k = 0; k < MAX_DIM; k++) begin
                res_ok_reg[k]  <= 1'b0;
                res_col_reg[k] <= '0;
            end
            j_reg    <= COL_W'(1);
            emit_reg <= '0;
        end
        if (cmd.res_scan) begin
            pend_row_reg <= tr ? IDX_W'(j_reg - 1'b1) : IDX_W'(owner_reg[j_reg] - 1'b1);
            pend_col_reg <= tr ? IDX_W'(owner_reg[j_reg] - 1'b1) : IDX_W'(j_reg - 1'b1);
        end
        if (cmd.res_chk) begin
            if (owner_reg[j_reg] != '0 && owner_reg[j_reg] <= n_dim && rd_feas_reg) begin
                res_ok_reg[pend_row_reg]  <= 1'b1;
                res_col_reg[pend_row_reg] <= pend_col_reg;
            end
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.emit_pop) emit_reg <= emit_reg + 1'b1;
    end

    always_comb begin
        sts.scan_last  = (j_reg == m_dim);
        sts.upd_last   = (j_reg == m_dim);
        sts.phase_done = (owner_reg[j1_reg] == '0);
        sts.aug_done   = (way_reg[j0_reg] == '0);
        sts.solve_done = (i_reg == n_dim);
        sts.res_last   = (j_reg == m_dim);
        sts.emit_last  = ({1'b0, emit_reg} == rows - 1'b1);
        m_data.row_index       = emit_reg;
        m_data.assigned_column = res_col_reg[emit_reg];
        m_data.matched         = res_ok_reg[emit_reg];
        m_data.last_row        = sts.emit_last;
    end

endmodule

>>> sv/hungarian_assignment_solver_core.sv
// ----------------------------------------------------------------------------
// Hungarian assignment solver core
// Loads a cost matrix and emits one minimum-cost assignment per original row.
// ----------------------------------------------------------------------------
//  Channel | Ports              | Moves
//  input   | s_valid/s_ready    | one matrix entry a beat, row-major
//  result  | m_valid/m_ready    | one row result a beat, rows in order
//  config  | APB psel..pready   | row_count at 0x0, col_count at 0x4
//
// The final entry beat starts a solve. Each augmenting step reads and compares
// every column (a store read, then a compare), then updates the potentials
// column by column; a row phase takes up to m steps and then a walk back along
// the path. Results are then gathered column by column (scan, read, check),
// then follow at one beat a cycle while m_ready is high.
// Reset is synchronous; no input beat is taken during solve or output.
module hungarian_assignment_solver_core import has_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  has_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output has_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DIM_W-1:0] row_count_reg, col_count_reg;
    logic             cfg_wr;
    has_cmd_t         cmd;
    has_sts_t         sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr == REG_ROW_COUNT || paddr == REG_COL_COUNT);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= DIM_W'(1);
            col_count_reg <= DIM_W'(1);
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_ROW_COUNT) row_count_reg <= pwdata[DIM_W-1:0];
            if (paddr == REG_COL_COUNT) col_count_reg <= pwdata[DIM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_ROW_COUNT) prdata = {27'd0, row_count_reg};
        else if (paddr == REG_COL_COUNT) prdata = {27'd0, col_count_reg};
    end

    has_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .cfg_wr  (cfg_wr),
        .sts     (sts),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    has_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule

>>> sv/has_checker.sv
// ----------------------------------------------------------------------------
// Hungarian solver port checker
// Watches the top-level ports for handshake and result ordering rules.
// ----------------------------------------------------------------------------
module has_checker import has_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input has_out_t m_data
);

    // A stalled result beat holds its payload.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Input and output never both open.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken during output");

    // Results start with row zero.
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_data.row_index == '0)
        else $error("first result not row zero");

    // An unmatched row reports column zero.
    a_unm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.matched |-> m_data.assigned_column == '0)
        else $error("unmatched row with column");

endmodule

bind hungarian_assignment_solver_core has_checker u_has_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/hungarian_assignment_solver_core_tb.sv
// ----------------------------------------------------------------------------
// Hungarian assignment solver core testbench
// Programs matrix sizes over APB, streams cost matrices through the entry
// channel and checks every row result against an in-bench assignment solver.
// ----------------------------------------------------------------------------
module hungarian_assignment_solver_core_tb;
    import has_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 100000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    has_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    has_out_t    m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hungarian_assignment_solver_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: programmed sizes and the matrix being loaded.
    logic [DIM_W-1:0]            rows_reg;
    logic [DIM_W-1:0]            cols_reg;
    logic signed [COST_BITS-1:0] mat_cost [STORE_DEPTH];
    logic                        mat_feas [STORE_DEPTH];
    int                          load_pos;
    logic [POT_W-1:0]            peak_mag;

    has_out_t expected_rows [$];
    int       fail_count;
    int       idle_cycles;

    // Cost of solver entry (i,k), reading the matrix transposed if needed.
    function automatic logic signed [POT_W-1:0] solver_cost(int i, int k, bit tr, int cols,
                                                            logic signed [POT_W-1:0] big);
        int r;
        int c;
        int idx;
        r = tr ? k : i;
        c = tr ? i : k;
        idx = (r * cols + c) % STORE_DEPTH;
        return mat_feas[idx] ? POT_W'(mat_cost[idx]) : big;
    endfunction

    // Accepts one entry beat and, on the final entry, solves and queues results.
    task automatic predict_entry(input has_in_t e);
        int rows;
        int cols;
        int n;
        int m;
        bit tr;
        logic [POT_W-1:0] mag;
        logic [63:0] bigu;
        logic signed [POT_W-1:0] big;
        logic signed [POT_W-1:0] u [MAX_DIM+1];
        logic signed [POT_W-1:0] v [MAX_DIM+1];
        logic signed [POT_W-1:0] minv [MAX_DIM+1];
        logic signed [POT_W-1:0] delta;
        logic signed [POT_W-1:0] cur;
        int p [MAX_DIM+1];
        int way [MAX_DIM+1];
        bit seen [MAX_DIM+1];
        bit mset [MAX_DIM+1];
        int res [MAX_DIM];
        int i0;
        int j0;
        int j1;
        int orow;
        int ocol;
        has_out_t o;
        rows = int'(eff_dim(rows_reg));
        cols = int'(eff_dim(cols_reg));
        if (load_pos >= rows * cols) load_pos = 0;
        mat_cost[load_pos] = e.cost_value;
        mat_feas[load_pos] = e.feasible;
        if (e.feasible) begin
            mag = e.cost_value < 0 ? -POT_W'(e.cost_value) : POT_W'(e.cost_value);
            if (mag > peak_mag) peak_mag = mag;
        end
        load_pos++;
        if (load_pos < rows * cols) return;

        bigu = (64'(peak_mag) + 64'd256) * 64'(rows + cols + 1);
        big = bigu > 64'(POT_MAX) ? POT_MAX : POT_W'(bigu);
        tr = rows > cols;
        n = tr ? cols : rows;
        m = tr ? rows : cols;
        for (int j = 0; j <= MAX_DIM; j++) begin
            u[j] = '0; v[j] = '0; p[j] = 0; way[j] = 0;
        end
        for (int i = 1; i <= n; i++) begin
            j0 = 0;
            p[0] = i;
            for (int j = 0; j <= m; j++) begin
                minv[j] = POT_MAX; mset[j] = 0; seen[j] = 0;
            end
            for (int it = 0; it <= m; it++) begin
                i0 = p[j0];
                j1 = 0;
                delta = POT_MAX;
                seen[j0] = 1;
                for (int j = 1; j <= m; j++) begin
                    if (!seen[j]) begin
                        cur = sat_sub(sat_sub(solver_cost(i0 - 1, j - 1, tr, cols, big),
                                              u[i0]), v[j]);
                        if (!mset[j] || cur < minv[j]) begin
                            minv[j] = cur; mset[j] = 1; way[j] = j0;
                        end
                        if (j1 == 0 || minv[j] < delta) begin
                            delta = minv[j]; j1 = j;
                        end
                    end
                end
                for (int j = 0; j <= m; j++) begin
                    if (seen[j]) begin
                        u[p[j]] = sat_add(u[p[j]], delta);
                        v[j] = sat_sub(v[j], delta);
                    end else begin
                        minv[j] = sat_sub(minv[j], delta);
                    end
                end
                j0 = j1;
                if (p[j0] == 0) break;
            end
            for (int it = 0; it <= m; it++) begin
                j1 = way[j0];
                p[j0] = p[j1];
                j0 = j1;
                if (j0 == 0) break;
            end
        end

        for (int r = 0; r < rows; r++) res[r] = -1;
        for (int r = 1; r <= m; r++) begin
            if (p[r] != 0 && p[r] <= n) begin
                orow = tr ? r - 1 : p[r] - 1;
                ocol = tr ? p[r] - 1 : r - 1;
                if (mat_feas[(orow * cols + ocol) % STORE_DEPTH]) res[orow] = ocol;
            end
        end
        for (int r = 0; r < rows; r++) begin
            o.row_index = IDX_W'(r);
            o.assigned_column = res[r] >= 0 ? IDX_W'(res[r]) : '0;
            o.matched = res[r] >= 0;
            o.last_row = (r == rows - 1);
            expected_rows.push_back(o);
        end
        load_pos = 0;
        peak_mag = '0;
    endtask

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: random back-pressure and comparison with the oldest expectation.
    initial begin
        int stall;
        has_out_t want;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    if (expected_rows.size() == 0) begin
                        $display("%0t: unexpected beat %p", $time, m_data);
                        fail_count++;
                    end else begin
                        want = expected_rows.pop_front();
                        if (m_data !== want) begin
                            $display("%0t: mismatch expected %p actual %p",
                                     $time, want, m_data);
                            fail_count++;
                        end
                    end
                    stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                    m_ready <= (stall == 0);
                end else if (!m_ready) begin
                    if (stall > 0) stall--;
                    if (stall == 0) m_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One APB write: setup phase, access phase, then idle.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        s_valid <= 1'b0;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_ROW_COUNT) rows_reg = data[DIM_W-1:0];
        else cols_reg = data[DIM_W-1:0];
        load_pos = 0;
        peak_mag = '0;
        @(posedge aclk);
    endtask

    // Waits for every expected row, then lets the solver settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // One entry beat after a random gap; valid stays high until the next call,
    // drain or APB write decides what follows.
    task automatic send_entry(input has_in_t e);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_entry(e);
    endtask

    function automatic has_in_t rand_entry(int mode);
        has_in_t e;
        e.cost_value = (mode == 0) ? COST_BITS'($urandom)
                                   : COST_BITS'($signed($urandom_range(0, 2000)) - 1000);
        e.feasible = ($urandom_range(0, 7) != 0);
        return e;
    endfunction

    // Directed rows: size write before the entries, or an entry.
    typedef struct {
        bit          is_cfg;
        logic [2:0]  addr;
        logic [31:0] val;
        has_in_t     entry;
    } step_t;

    initial begin
        step_t steps [$];
        step_t st;
        int rows;
        int cols;
        int mode;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        rows_reg = DIM_W'(1);
        cols_reg = DIM_W'(1);
        load_pos = 0;
        peak_mag = '0;
        fail_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset sizes 1x1: a single feasible entry matches column zero.
        s_valid <= 1'b1;
        s_data <= '{cost_value: 24'sh7FFFFF, feasible: 1'b1};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_entry('{cost_value: 24'sh7FFFFF, feasible: 1'b1});
        expected_rows.delete();
        expected_rows.push_back('{row_index: 4'd0, assigned_column: 4'd0,
                                  matched: 1'b1, last_row: 1'b1});
        drain();

        // Directed: infeasible 1x1, zero sizes, transposed 3x2, 2x4, oversize.
        steps.push_back('{0, 3'd0, 0, '{cost_value: 24'sh800000, feasible: 1'b0}});
        steps.push_back('{1, REG_ROW_COUNT, 32'd0, '0});
        steps.push_back('{1, REG_COL_COUNT, 32'd0, '0});
        steps.push_back('{0, 3'd0, 0, '{cost_value: 24'sh800000, feasible: 1'b1}});
        steps.push_back('{1, REG_ROW_COUNT, 32'd3, '0});
        steps.push_back('{1, REG_COL_COUNT, 32'd2, '0});
        for (int k = 0; k < 6; k++)
            steps.push_back('{0, 3'd0, 0, '{cost_value: COST_BITS'(k * 37 - 90),
                                           feasible: (k != 1)}});
        steps.push_back('{1, REG_ROW_COUNT, 32'd2, '0});
        steps.push_back('{1, REG_COL_COUNT, 32'd4, '0});
        for (int k = 0; k < 8; k++)
            steps.push_back('{0, 3'd0, 0, '{cost_value: (k[0] ? 24'sh7FFFFF : 24'sh800000),
                                           feasible: (k < 6)}});
        steps.push_back('{1, REG_ROW_COUNT, 32'd31, '0});
        steps.push_back('{1, REG_COL_COUNT, 32'd1, '0});
        foreach (steps[i]) begin
            st = steps[i];
            if (st.is_cfg) begin
                drain();
                apb_write(st.addr, st.val);
            end else begin
                send_entry(st.entry);
            end
        end
        // Finish the 16x1 matrix, with a size rewrite midway to restart loading.
        for (int k = 0; k < 5; k++) send_entry(rand_entry(0));
        apb_write(REG_COL_COUNT, 32'd1);
        for (int k = 0; k < 16; k++) send_entry(rand_entry(1));
        drain();

        // Random matrices, mostly small, a full-size one only while it fits the budget.
        for (int total = 0; total < 270;) begin
            drain();
            if (total + 256 <= 270 && $urandom_range(0, 9) == 0) begin
                rows = 16; cols = 16;
            end else begin
                rows = $urandom_range(1, 5); cols = $urandom_range(1, 5);
            end
            apb_write(REG_ROW_COUNT, 32'(rows) | ($urandom & 32'hFFFF_FFE0));
            apb_write(REG_COL_COUNT, 32'(cols));
            mode = $urandom_range(0, 2);
            for (int k = 0; k < rows * cols; k++) send_entry(rand_entry(mode));
            total += rows * cols;
        end
        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/has_pkg.sv
sv/has_ctrl.sv
sv/has_dp.sv
sv/hungarian_assignment_solver_core.sv
sv/has_checker.sv
tb/hungarian_assignment_solver_core_tb.sv
